/* src/mmrb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mmrb_pkg
// Shared types and constants for the multichannel mixing ring buffer: item
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package mmrb_pkg;

	localparam int FRAMES_DEF       = 4096;
	localparam int MAX_CHANNELS_DEF = 8;

	localparam int POS_W    = 12;
	localparam int CHAN_W   = 3;
	localparam int SAMPLE_W = 24;
	localparam int CIU_W    = 4;

	localparam logic [CIU_W-1:0] CIU_RESET = 4'd2;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

	typedef enum logic {
		OP_MIX   = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		SRC_POSITION = 2'd0,
		SRC_READ_PTR = 2'd1,
		SRC_CURSOR   = 2'd2
	} src_t;

	typedef enum logic {
		KIND_REPORT = 1'b0,
		KIND_DRAIN  = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MIX,
		ST_REPORT,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic capture;   // latch an accepted transaction
		logic clear_wr;  // zero one store entry of the clearing pass
		logic mix_wr;    // write back the saturated sum, move the cursor
		logic report;    // load a position report into the output register
		logic drain_wr;  // load a drained sample and zero its slot
		logic cnt_inc;   // next channel of a drain
		logic rp_adv;    // advance the read pointer
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_drain;
		logic run_last;
		logic last_ch;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

/* src/mmrb_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mmrb_ctrl
// Sequencer: clearing pass after reset, read-modify-write of a mix and the
// per-channel read-and-clear loop of a drain.
// ----------------------------------------------------------------------------
module mmrb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire mmrb_pkg::status_t status,
	output mmrb_pkg::cmd_t         cmd
);

	mmrb_pkg::state_t state_q;
	mmrb_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmrb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mmrb_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clr_done) begin
					state_d = mmrb_pkg::ST_IDLE;
				end
			end
			mmrb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = mmrb_pkg::ST_READ;
				end
			end
			mmrb_pkg::ST_READ: begin
				// store read issued here, data registered for the next state
				state_d = status.is_drain ? mmrb_pkg::ST_DRAIN : mmrb_pkg::ST_MIX;
			end
			mmrb_pkg::ST_MIX: begin
				cmd.mix_wr = 1'b1;
				state_d    = status.run_last ? mmrb_pkg::ST_REPORT : mmrb_pkg::ST_IDLE;
			end
			mmrb_pkg::ST_REPORT: begin
				if (status.out_free) begin
					cmd.report = 1'b1;
					state_d    = mmrb_pkg::ST_IDLE;
				end
			end
			mmrb_pkg::ST_DRAIN: begin
				if (status.out_free) begin
					cmd.drain_wr = 1'b1;
					if (status.last_ch) begin
						cmd.rp_adv = 1'b1;
						state_d    = mmrb_pkg::ST_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
						state_d     = mmrb_pkg::ST_READ;
					end
				end
			end
			default: begin
				state_d = mmrb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* src/mmrb_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mmrb_datapath
// Mix store (single-port, registered read), pointers, channel count register,
// saturating adder and the output register.
// ----------------------------------------------------------------------------
module mmrb_datapath #(
	parameter int FRAMES       = mmrb_pkg::FRAMES_DEF,
	parameter int MAX_CHANNELS = mmrb_pkg::MAX_CHANNELS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire mmrb_pkg::cmd_t                        cmd,
	output mmrb_pkg::status_t                          status,
	input  wire logic                                  cfg_wr_en,
	input  wire logic        [mmrb_pkg::CIU_W-1:0]     cfg_wr_data,
	input  wire logic                                  opcode,
	input  wire logic        [1:0]                     position_source,
	input  wire logic        [mmrb_pkg::POS_W-1:0]     position,
	input  wire logic        [mmrb_pkg::CHAN_W-1:0]    channel,
	input  wire logic signed [mmrb_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                                  run_last,
	input  wire logic                                  out_ready,
	output logic                                       out_valid,
	output logic                                       kind,
	output logic             [mmrb_pkg::POS_W-1:0]     next_position,
	output logic             [mmrb_pkg::CHAN_W-1:0]    out_channel,
	output logic signed      [mmrb_pkg::SAMPLE_W-1:0]  out_sample,
	output logic                                       last
);

	localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int NW    = (CNT_W > mmrb_pkg::CIU_W) ? CNT_W : mmrb_pkg::CIU_W;
	localparam int AW    = FW + CH_W;
	localparam int DEPTH = FRAMES << CH_W;
	localparam int MW    = (FW + 1 > mmrb_pkg::POS_W) ? FW + 1 : mmrb_pkg::POS_W;

	// explicit position folded into the ring, at most three subtractions
	function automatic logic [FW-1:0] wrap_pos(input logic [mmrb_pkg::POS_W-1:0] p);
		logic [MW-1:0] v;
		v = MW'(p);
		for (int i = 0; i < 3; i++) begin
			if (v >= MW'(FRAMES)) begin
				v = v - MW'(FRAMES);
			end
		end
		return FW'(v);
	endfunction

	function automatic logic [FW-1:0] next_frame(input logic [FW-1:0] f);
		return (f == FW'(FRAMES - 1)) ? '0 : f + 1'b1;
	endfunction

	logic signed [mmrb_pkg::SAMPLE_W-1:0] mix_store_q [DEPTH];
	logic signed [mmrb_pkg::SAMPLE_W-1:0] rdata_q;

	logic [mmrb_pkg::CIU_W-1:0]            ciu_q;
	logic [FW-1:0]                         rp_q;
	logic [FW-1:0]                         wc_q;
	logic [AW-1:0]                         clr_q;
	logic [FW-1:0]                         frame_q;
	logic [mmrb_pkg::CHAN_W-1:0]           chan_q;
	logic signed [mmrb_pkg::SAMPLE_W-1:0]  sample_q;
	logic                                  run_last_q;
	mmrb_pkg::op_t                         op_q;
	logic [CNT_W-1:0]                      cnt_q;
	logic                                  out_valid_q;

	logic [FW-1:0]                         frame_d;
	logic [NW-1:0]                         ciu_x;
	logic [NW-1:0]                         n_eff;
	logic                                  in_use;
	logic [AW-1:0]                         addr;
	logic                                  mem_we;
	logic signed [mmrb_pkg::SAMPLE_W-1:0]  mem_wdata;
	logic signed [mmrb_pkg::SAMPLE_W:0]    sum;
	logic signed [mmrb_pkg::SAMPLE_W-1:0]  sat;

	// effective channel count: zero acts as one, clamp at the store width
	always_comb begin
		ciu_x = NW'(ciu_q);
		if (ciu_x == '0) begin
			n_eff = NW'(1);
		end else if (ciu_x > NW'(MAX_CHANNELS)) begin
			n_eff = NW'(MAX_CHANNELS);
		end else begin
			n_eff = ciu_x;
		end
	end

	assign in_use = (NW'(chan_q) < n_eff);

	always_comb begin
		if (opcode == mmrb_pkg::OP_DRAIN) begin
			frame_d = rp_q;
		end else begin
			case (position_source)
				mmrb_pkg::SRC_POSITION: frame_d = wrap_pos(position);
				mmrb_pkg::SRC_READ_PTR: frame_d = rp_q;
				default:                frame_d = wc_q;
			endcase
		end
	end

	assign sum = {rdata_q[mmrb_pkg::SAMPLE_W-1], rdata_q}
	           + {sample_q[mmrb_pkg::SAMPLE_W-1], sample_q};

	always_comb begin
		if (sum[mmrb_pkg::SAMPLE_W] != sum[mmrb_pkg::SAMPLE_W-1]) begin
			sat = sum[mmrb_pkg::SAMPLE_W] ? mmrb_pkg::SAMPLE_MIN : mmrb_pkg::SAMPLE_MAX;
		end else begin
			sat = sum[mmrb_pkg::SAMPLE_W-1:0];
		end
	end

	always_comb begin
		if (cmd.clear_wr) begin
			addr = clr_q;
		end else if (op_q == mmrb_pkg::OP_DRAIN) begin
			addr = {frame_q, CH_W'(cnt_q)};
		end else begin
			addr = {frame_q, CH_W'(chan_q)};
		end
		mem_we    = cmd.clear_wr | cmd.drain_wr | (cmd.mix_wr & in_use);
		mem_wdata = cmd.mix_wr ? sat : '0;
	end

	// single port, read-before-write
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mix_store_q[addr] <= mem_wdata;
		end
		rdata_q <= mix_store_q[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ciu_q       <= mmrb_pkg::CIU_RESET;
			rp_q        <= '0;
			wc_q        <= '0;
			clr_q       <= '0;
			cnt_q       <= '0;
			op_q        <= mmrb_pkg::OP_MIX;
			run_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				ciu_q <= cfg_wr_data;
			end
			if (cmd.clear_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.capture) begin
				op_q       <= mmrb_pkg::op_t'(opcode);
				run_last_q <= run_last;
				cnt_q      <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.mix_wr) begin
				wc_q <= next_frame(frame_q);
			end
			if (cmd.rp_adv) begin
				rp_q <= next_frame(frame_q);
			end
			if (cmd.report || cmd.drain_wr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			frame_q  <= frame_d;
			chan_q   <= channel;
			sample_q <= sample;
		end
		if (cmd.report) begin
			kind          <= mmrb_pkg::KIND_REPORT;
			next_position <= mmrb_pkg::POS_W'(wc_q);
			out_channel   <= '0;
			out_sample    <= '0;
			last          <= 1'b1;
		end else if (cmd.drain_wr) begin
			kind          <= mmrb_pkg::KIND_DRAIN;
			next_position <= mmrb_pkg::POS_W'(frame_q);
			out_channel   <= mmrb_pkg::CHAN_W'(cnt_q);
			out_sample    <= rdata_q;
			last          <= status.last_ch;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.clr_done = (clr_q == AW'(DEPTH - 1));
	assign status.is_drain = (op_q == mmrb_pkg::OP_DRAIN);
	assign status.run_last = run_last_q;
	assign status.last_ch  = ((NW'(cnt_q) + NW'(1)) == n_eff);
	assign status.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

/* src/multichannel_mix_ring_buffer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_mix_ring_buffer
// Frame-by-channel ring store: mixes samples into slots with saturation and
// drains whole frames with read-and-clear.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_ready   | opcode position_source position channel
//          |                       | sample run_last
//  out     | out_valid / out_ready | kind next_position out_channel
//          |                       | out_sample last
//  cfg     | cfg_wr_en             | cfg_wr_data (channels in use)
//
// a mix is a store read then a write-back, plus a position report when run_last
// is set; a drain reads and clears each channel in use in turn: every slot access
// is a read-modify-write on the one port of the store. after reset a clearing
// pass over all FRAMES * 2**max(1, clog2(MAX_CHANNELS)) entries (32768 at the
// defaults) zeroes the store with in_ready low.
// a stalled output register holds the sequencer until the result is taken.
// ----------------------------------------------------------------------------
module multichannel_mix_ring_buffer #(
	parameter int FRAMES       = mmrb_pkg::FRAMES_DEF,
	parameter int MAX_CHANNELS = mmrb_pkg::MAX_CHANNELS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic        [mmrb_pkg::CIU_W-1:0]     cfg_wr_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  opcode,
	input  wire logic        [1:0]                     position_source,
	input  wire logic        [mmrb_pkg::POS_W-1:0]     position,
	input  wire logic        [mmrb_pkg::CHAN_W-1:0]    channel,
	input  wire logic signed [mmrb_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                                  run_last,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic                                       kind,
	output logic             [mmrb_pkg::POS_W-1:0]     next_position,
	output logic             [mmrb_pkg::CHAN_W-1:0]    out_channel,
	output logic signed      [mmrb_pkg::SAMPLE_W-1:0]  out_sample,
	output logic                                       last
);

	mmrb_pkg::cmd_t    cmd;
	mmrb_pkg::status_t status;

	mmrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mmrb_datapath #(
		.FRAMES       (FRAMES),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.opcode          (opcode),
		.position_source (position_source),
		.position        (position),
		.channel         (channel),
		.sample          (sample),
		.run_last        (run_last),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.kind            (kind),
		.next_position   (next_position),
		.out_channel     (out_channel),
		.out_sample      (out_sample),
		.last            (last)
	);

endmodule
`default_nettype wire

/* verif/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multichannel mixing ring buffer. A table of
// hand-picked transactions runs first; then randomized mix runs, drains and
// noise run under several channel counts, and a closing stretch with no
// idling. All results are checked against a behavioral copy of the store.
// ----------------------------------------------------------------------------
module testbench;
	import mmrb_pkg::*;

	localparam int N_FRAMES      = FRAMES_DEF;
	localparam int N_CH          = MAX_CHANNELS_DEF;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 160;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_PCT      = 22;
	localparam int SHOW_MAX      = 10;
	localparam int PHASE_ITEMS   = 52;
	localparam int WALK_ITEMS    = 60;

	// source code that the block treats like the write cursor
	localparam logic [1:0] SRC_UNUSED = 2'd3;

	typedef struct packed {
		op_t                        op;
		logic [1:0]                 src;
		logic [POS_W-1:0]           pos;
		logic [CHAN_W-1:0]          ch;
		logic signed [SAMPLE_W-1:0] smp;
		logic                       rl;
	} ring_item_t;

	typedef struct packed {
		kind_t                      kind;
		logic [POS_W-1:0]           pos;
		logic [CHAN_W-1:0]          ch;
		logic signed [SAMPLE_W-1:0] smp;
		logic                       last;
	} ring_result_t;

	// typed values, where present, replace position and sample of the first result
	typedef struct packed {
		ring_item_t                 item;
		logic                       typed;
		logic [POS_W-1:0]           t_pos;
		logic signed [SAMPLE_W-1:0] t_smp;
	} stim_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [CIU_W-1:0]           cfg_wr_data;
	logic                       in_valid;
	logic                       in_ready;
	logic                       opcode;
	logic [1:0]                 position_source;
	logic [POS_W-1:0]           position;
	logic [CHAN_W-1:0]          channel;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       run_last;
	logic                       out_valid;
	logic                       out_ready;
	logic                       kind;
	logic [POS_W-1:0]           next_position;
	logic [CHAN_W-1:0]          out_channel;
	logic signed [SAMPLE_W-1:0] out_sample;
	logic                       last;

	// behavioral copy of the block
	logic signed [SAMPLE_W-1:0] ring_model [N_FRAMES][N_CH];
	logic [POS_W-1:0]           rd_ptr_m;
	logic [POS_W-1:0]           wr_cur_m;
	logic [CIU_W-1:0]           ciu_m;
	ring_result_t               ring_results_due[$];

	stim_row_t dir_rows[$];
	int        phase_ch [7] = '{1, 8, 0, 15, 5, 3, 7};
	int        err_count    = 0;
	int        cycle_count  = 0;
	int        hold_asked   = 0;
	int        hold_served  = 0;
	logic      steady       = 1'b0;

	multichannel_mix_ring_buffer DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.position_source (position_source),
		.position        (position),
		.channel         (channel),
		.sample          (sample),
		.run_last        (run_last),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.next_position   (next_position),
		.out_channel     (out_channel),
		.out_sample      (out_sample),
		.last            (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int effective_channels();
		int n;
		n = ciu_m;
		if (n < 1)
			n = 1;
		if (n > N_CH)
			n = N_CH;
		return n;
	endfunction

	// applies one accepted transaction to the model, queues its results
	function automatic int mix_ring_step(input ring_item_t it);
		int                         n;
		logic [POS_W-1:0]           frame;
		logic signed [SAMPLE_W:0]   sum;
		ring_result_t               r;
		n = effective_channels();
		if (it.op == OP_DRAIN) begin
			for (int c = 0; c < n; c++) begin
				r.kind = KIND_DRAIN;
				r.pos  = rd_ptr_m;
				r.ch   = c[CHAN_W-1:0];
				r.smp  = ring_model[rd_ptr_m][c];
				r.last = (c == n - 1);
				ring_model[rd_ptr_m][c] = '0;
				ring_results_due.insert(ring_results_due.size(), r);
			end
			rd_ptr_m = rd_ptr_m + 1'b1;
			return n;
		end
		case (it.src)
			SRC_POSITION: frame = it.pos;
			SRC_READ_PTR: frame = rd_ptr_m;
			default:      frame = wr_cur_m;
		endcase
		if (it.ch < n) begin
			sum = ring_model[frame][it.ch] + it.smp;
			ring_model[frame][it.ch] = (sum > SAMPLE_MAX) ? SAMPLE_MAX :
				(sum < SAMPLE_MIN) ? SAMPLE_MIN : sum[SAMPLE_W-1:0];
		end
		wr_cur_m = frame + 1'b1;
		if (!it.rl)
			return 0;
		r.kind = KIND_REPORT;
		r.pos  = wr_cur_m;
		r.ch   = '0;
		r.smp  = '0;
		r.last = 1'b1;
		ring_results_due.insert(ring_results_due.size(), r);
		return 1;
	endfunction

	function automatic void add_row(input op_t op, input logic [1:0] src, input int pos,
		input int ch, input int smp, input int rl, input int typed, input int tpos,
		input int tsmp);
		stim_row_t row;
		row.item.op  = op;
		row.item.src = src;
		row.item.pos = POS_W'(pos);
		row.item.ch  = CHAN_W'(ch);
		row.item.smp = SAMPLE_W'(smp);
		row.item.rl  = (rl != 0);
		row.typed    = (typed != 0);
		row.t_pos    = POS_W'(tpos);
		row.t_smp    = SAMPLE_W'(tsmp);
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return SAMPLE_MAX;
		if (pick < 30)
			return SAMPLE_MIN;
		if (pick < 40)
			return SAMPLE_W'($urandom_range(15) - 8);
		return SAMPLE_W'($urandom);
	endfunction

	function automatic ring_item_t noise_item();
		ring_item_t it;
		it.op  = op_t'($urandom_range(1));
		it.src = 2'($urandom_range(3));
		it.pos = POS_W'($urandom);
		it.ch  = CHAN_W'($urandom);
		it.smp = SAMPLE_W'($urandom);
		it.rl  = 1'($urandom_range(1));
		return it;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic offer(input stim_row_t row);
		int           n;
		int           idx;
		ring_result_t fix;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		opcode          <= row.item.op;
		position_source <= row.item.src;
		position        <= row.item.pos;
		channel         <= row.item.ch;
		sample          <= row.item.smp;
		run_last        <= row.item.rl;
		in_valid        <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		n = mix_ring_step(row.item);
		if (row.typed && n > 0) begin
			idx     = ring_results_due.size() - n;
			fix     = ring_results_due[idx];
			fix.pos = row.t_pos;
			fix.smp = row.t_smp;
			ring_results_due[idx] = fix;
		end
		@(negedge clk);
	endtask

	task automatic write_channels(input logic [CIU_W-1:0] v);
		cfg_wr_data <= v;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		ciu_m = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// sender pause: nothing offered until every result is back
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (ring_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly well-formed mix runs near the read pointer, plus drains and noise
	task automatic random_traffic(input int n_items);
		int        sent;
		int        len;
		int        sel;
		int        pick;
		stim_row_t row;
		sent = 0;
		while (sent < n_items) begin
			sel = $urandom_range(99);
			if (sel < 55) begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					row         = '0;
					row.item.op = OP_MIX;
					pick        = $urandom_range(9);
					if (k != 0)
						row.item.src = ($urandom_range(7) == 0) ? SRC_UNUSED : SRC_CURSOR;
					else if (pick < 4)
						row.item.src = SRC_READ_PTR;
					else begin
						row.item.src = SRC_POSITION;
						row.item.pos = (pick < 8) ? POS_W'(rd_ptr_m + $urandom_range(3)) :
							POS_W'($urandom);
					end
					if (row.item.src != SRC_POSITION)
						row.item.pos = POS_W'($urandom);
					row.item.ch  = CHAN_W'(($urandom_range(4) != 0) ?
						$urandom_range(effective_channels() - 1) : $urandom_range(7));
					row.item.smp = rand_sample();
					// a run now and then ends without its report
					row.item.rl  = (k == len - 1) && ($urandom_range(9) != 0);
					offer(row);
					sent++;
				end
			end else begin
				row      = '0;
				row.item = noise_item();
				if (sel < 85)
					row.item.op = OP_DRAIN;
				offer(row);
				sent++;
			end
		end
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served < hold_asked) begin
				hold_served++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin : result_check
		ring_result_t want;
		if (out_valid && out_ready) begin
			if (ring_results_due.size() == 0) begin
				err_count++;
				if (err_count <= SHOW_MAX)
					$display("unexpected transaction: kind %0d pos %0d ch %0d smp %0d last %0d",
						kind, next_position, out_channel, out_sample, last);
			end else begin
				want = ring_results_due.pop_front();
				if (kind !== want.kind || next_position !== want.pos ||
					out_channel !== want.ch || out_sample !== want.smp ||
					last !== want.last) begin
					err_count++;
					if (err_count <= SHOW_MAX)
						$display("mismatch: exp kind %0d pos %0d ch %0d smp %0d last %0d, %s",
							want.kind, want.pos, want.ch, $signed(want.smp), want.last,
							$sformatf("got kind %0d pos %0d ch %0d smp %0d last %0d",
							kind, next_position, out_channel, out_sample, last));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[multichannel_mix_ring_buffer] ERROR");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = CIU_RESET;
		in_valid        = 1'b0;
		opcode          = OP_MIX;
		position_source = SRC_POSITION;
		position        = '0;
		channel         = '0;
		sample          = '0;
		run_last        = 1'b0;
		for (int f = 0; f < N_FRAMES; f++)
			for (int c = 0; c < N_CH; c++)
				ring_model[f][c] = '0;
		rd_ptr_m = '0;
		wr_cur_m = '0;
		ciu_m    = CIU_RESET;
		phase_ch[5] = $urandom_range(1, 7);
		phase_ch[6] = $urandom_range(15);

		// two channels in use from reset; drains ignore all other fields
		add_row(OP_DRAIN, SRC_CURSOR, 4095, 7, -1, 1, 1, 0, 0);
		add_row(OP_MIX, SRC_POSITION, 4095, 0, SAMPLE_MAX, 1, 1, 0, 0);
		add_row(OP_MIX, SRC_POSITION, 4095, 0, 1, 1, 1, 0, 0);
		add_row(OP_MIX, SRC_POSITION, 4095, 1, SAMPLE_MIN, 0, 0, 0, 0);
		add_row(OP_MIX, SRC_POSITION, 4095, 1, -1, 1, 1, 0, 0);
		add_row(OP_MIX, SRC_UNUSED, 0, 1, 5, 1, 1, 1, 0);
		add_row(OP_MIX, SRC_CURSOR, 0, 0, -7, 1, 1, 2, 0);
		add_row(OP_MIX, SRC_READ_PTR, 0, 0, 100, 1, 1, 2, 0);
		// channels beyond the count in use add nothing
		add_row(OP_MIX, SRC_POSITION, 1, 7, 1234, 1, 1, 2, 0);
		add_row(OP_MIX, SRC_POSITION, 1, 2, SAMPLE_MAX, 0, 0, 0, 0);
		add_row(OP_DRAIN, SRC_UNUSED, 'hFFF, 7, SAMPLE_MIN, 0, 1, 1, 93);
		add_row(OP_MIX, SRC_POSITION, 'hAAA, 5, 'h555555, 1, 1, 'hAAB, 0);
		add_row(OP_MIX, SRC_POSITION, 'h555, 1, -'h555556, 1, 1, 'h556, 0);
		add_row(OP_MIX, SRC_READ_PTR, 0, 1, SAMPLE_MAX, 0, 0, 0, 0);
		add_row(OP_MIX, SRC_CURSOR, 0, 1, SAMPLE_MAX, 0, 0, 0, 0);
		add_row(OP_MIX, SRC_CURSOR, 0, 0, SAMPLE_MIN, 1, 1, 5, 0);
		add_row(OP_DRAIN, SRC_POSITION, 0, 0, 0, 0, 1, 2, 0);
		add_row(OP_DRAIN, SRC_POSITION, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_DRAIN, SRC_POSITION, 0, 0, 0, 0, 1, 4, SAMPLE_MIN);
		add_row(OP_DRAIN, SRC_POSITION, 0, 0, 0, 0, 1, 5, 0);
		add_row(OP_MIX, SRC_POSITION, 0, 0, SAMPLE_MIN, 1, 1, 1, 0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			offer(dir_rows[i]);
		wait_all_results();

		foreach (phase_ch[p]) begin
			write_channels(CIU_W'(phase_ch[p]));
			steady = (p == 2);
			// receiver stalls long enough to back up the input
			if (p == 1)
				hold_asked++;
			random_traffic(PHASE_ITEMS);
			wait_all_results();
		end

		// closing stretch of drains and read-pointer mixes, no idling
		write_channels(CIU_W'(15));
		steady = 1'b1;
		for (int k = 0; k < WALK_ITEMS; k++) begin
			row      = '0;
			row.item = noise_item();
			if ($urandom_range(4) == 0) begin
				row.item.op  = OP_MIX;
				row.item.src = SRC_READ_PTR;
				row.item.smp = rand_sample();
			end else begin
				row.item.op = OP_DRAIN;
			end
			offer(row);
		end
		wait_all_results();
		steady = 1'b0;

		if (err_count == 0)
			$display("[multichannel_mix_ring_buffer] OK");
		else
			$display("[multichannel_mix_ring_buffer] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
